>>> src/daily_light_feeder_scheduler_unit_assert.svh
// Assertion macros used by the scheduler top level.
`ifndef DAILY_LIGHT_FEEDER_SCHEDULER_UNIT_ASSERT_SVH
`define DAILY_LIGHT_FEEDER_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and disabled during reset.
`define DLFS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, sampled on i_clk and disabled during reset.
`define DLFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

>>> src/dlfs_pkg.sv
// Types and constants of the daily light and feeder scheduler.
`default_nettype none

package dlfs_pkg;

    localparam int MINUTE_W  = 11;
    localparam int MS_W      = 32;
    localparam int GRAMS_W   = 10;
    localparam int SPAN_W    = 27;
    localparam int FEED_MS_W = 18;

    typedef logic [MINUTE_W-1:0]  t_minute;
    typedef logic [MS_W-1:0]      t_ms;
    typedef logic [GRAMS_W-1:0]   t_grams;
    typedef logic [SPAN_W-1:0]    t_span;
    typedef logic [FEED_MS_W-1:0] t_feed_ms;

    localparam t_minute DAY_MINUTES    = 11'd1440;
    localparam t_minute LIGHT_TRIM_MIN = 11'd5;
    localparam t_ms     ACTION_MS      = 32'd300000;
    localparam t_ms     FEED_GAP_MS    = 32'd60000;
    localparam int      MS_PER_MINUTE  = 60000;
    localparam int      MS_PER_GRAM    = 200;

    // Register indexes on the configuration port; feed slots follow the last one.
    localparam int REG_SUNRISE     = 0;
    localparam int REG_SUNSET      = 1;
    localparam int REG_FEED_AMOUNT = 2;
    localparam int REG_FEED_SLOT0  = 3;

    localparam t_minute RST_SUNRISE   = 11'd375;
    localparam t_minute RST_SUNSET    = 11'd1210;
    localparam t_grams  RST_FEED_AMT  = 10'd0;
    localparam t_minute RST_FEED_SLOT = 11'd2047;

    typedef struct packed {
        t_minute minute_of_day;
        t_ms     now_ms;
        logic    feed_now;
    } t_tick;

    typedef struct packed {
        t_minute  sunrise_minute;
        t_minute  sunset_minute;
        t_feed_ms feed_ms;
        t_span    span_ms;
    } t_cfg;

    typedef struct packed {
        logic sunrise_pulse;
        logic sunset_pulse;
        logic light_on;
        logic feeder_on;
    } t_result;

endpackage

`default_nettype wire

>>> src/dlfs_core.sv
// Per-tick scheduling logic and the busy flags and time stamps it keeps.
`default_nettype none

module dlfs_core #(
    parameter int FEED_SLOTS = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire dlfs_pkg::t_tick  i_tick,
    input  wire dlfs_pkg::t_cfg   i_cfg,
    input  wire dlfs_pkg::t_minute i_feed_slot [FEED_SLOTS],
    output dlfs_pkg::t_result     o_result
);
    import dlfs_pkg::*;

    logic r_sunrise_busy, r_sunset_busy, r_light_busy, r_feeder_busy;
    t_ms  r_sunrise_stamp, r_sunset_stamp, r_light_stamp, r_feeder_stamp, r_last_feed_stamp;

    logic n_sunrise_busy, n_sunset_busy, n_light_busy, n_feeder_busy;
    t_ms  n_sunrise_stamp, n_sunset_stamp, n_light_stamp, n_feeder_stamp, n_last_feed_stamp;

    logic manual_start, rise_start, set_start, slot_hit, slot_start, light_start;
    logic rise_busy1, set_busy1, feeder_busy1, light_busy1;
    t_ms  now, rise_stamp1, set_stamp1, feeder_stamp1, last_stamp1, light_stamp1;
    t_ms  rise_age, set_age, feeder_age, light_age, gap_age;
    t_minute minute;

    always_comb begin
        now    = i_tick.now_ms;
        minute = i_tick.minute_of_day;

        // A manual request only starts an idle feeder.
        manual_start = i_tick.feed_now && !r_feeder_busy;
        feeder_busy1 = r_feeder_busy || manual_start;
        feeder_stamp1 = manual_start ? now : r_feeder_stamp;
        last_stamp1   = manual_start ? now : r_last_feed_stamp;

        rise_start = (i_cfg.sunrise_minute < DAY_MINUTES) &&
                     (minute == i_cfg.sunrise_minute) && !r_sunrise_busy;
        set_start  = (i_cfg.sunset_minute < DAY_MINUTES) &&
                     (minute == i_cfg.sunset_minute) && !r_sunset_busy;
        rise_busy1  = r_sunrise_busy || rise_start;
        set_busy1   = r_sunset_busy || set_start;
        rise_stamp1 = rise_start ? now : r_sunrise_stamp;
        set_stamp1  = set_start ? now : r_sunset_stamp;

        slot_hit = 1'b0;
        for (int k = 0; k < FEED_SLOTS; k++) begin
            if (i_feed_slot[k] < DAY_MINUTES && i_feed_slot[k] == minute) begin
                slot_hit = 1'b1;
            end
        end
        // After the first slot start the gap to itself is zero, so one start is enough.
        gap_age    = now - last_stamp1;
        slot_start = slot_hit && (gap_age >= FEED_GAP_MS);
        if (slot_start) begin
            feeder_busy1  = 1'b1;
            feeder_stamp1 = now;
            last_stamp1   = now;
        end

        rise_age    = now - rise_stamp1;
        light_start = rise_busy1 && !r_light_busy && (rise_age >= ACTION_MS);
        light_busy1  = r_light_busy || light_start;
        light_stamp1 = light_start ? now : r_light_stamp;
        light_age    = now - light_stamp1;

        n_light_busy  = light_busy1 && !(light_age >= MS_W'(i_cfg.span_ms));
        n_light_stamp = light_stamp1;

        feeder_age     = now - feeder_stamp1;
        n_feeder_busy  = feeder_busy1 && !(feeder_age >= MS_W'(i_cfg.feed_ms)) &&
                         (i_cfg.feed_ms != '0);
        n_feeder_stamp    = feeder_stamp1;
        n_last_feed_stamp = last_stamp1;

        set_age        = now - set_stamp1;
        n_sunrise_busy = rise_busy1 && !(rise_age >= ACTION_MS) && (minute != '0);
        n_sunset_busy  = set_busy1 && !(set_age >= ACTION_MS) && (minute != '0);
        n_sunrise_stamp = rise_stamp1;
        n_sunset_stamp  = set_stamp1;

        o_result.sunrise_pulse = rise_start;
        o_result.sunset_pulse  = set_start;
        o_result.light_on      = n_light_busy;
        o_result.feeder_on     = n_feeder_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sunrise_busy    <= 1'b0;
            r_sunset_busy     <= 1'b0;
            r_light_busy      <= 1'b0;
            r_feeder_busy     <= 1'b0;
            r_sunrise_stamp   <= '0;
            r_sunset_stamp    <= '0;
            r_light_stamp     <= '0;
            r_feeder_stamp    <= '0;
            r_last_feed_stamp <= '0;
        end else if (i_step) begin
            r_sunrise_busy    <= n_sunrise_busy;
            r_sunset_busy     <= n_sunset_busy;
            r_light_busy      <= n_light_busy;
            r_feeder_busy     <= n_feeder_busy;
            r_sunrise_stamp   <= n_sunrise_stamp;
            r_sunset_stamp    <= n_sunset_stamp;
            r_light_stamp     <= n_light_stamp;
            r_feeder_stamp    <= n_feeder_stamp;
            r_last_feed_stamp <= n_last_feed_stamp;
        end
    end

endmodule

`default_nettype wire

>>> src/daily_light_feeder_scheduler_unit.sv
// Top level of the daily light and feeder scheduler: ports, configuration and pipeline.
// A tick request passes the input register, then the result register, on its way to a result;
// throughput is one tick request per cycle while the output side does not stall.
// All slot and stamp compares run in parallel in the single logic stage between them.
// Reset (synchronous, active low) empties both registers, clears all busy flags
// and stamps, and loads the configuration registers with their defaults.
`default_nettype none

`include "daily_light_feeder_scheduler_unit_assert.svh"

module daily_light_feeder_scheduler_unit #(
    parameter int FEED_SLOTS = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [10:0] minute_of_day, [42:11] now_ms, [43] feed_now, [47:44] zero
    input  wire logic [47:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [0] sunrise_pulse, [1] sunset_pulse, [2] light_on, [3] feeder_on, [7:4] zero
    output logic [7:0]       o_m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [$clog2(4*(3+FEED_SLOTS))-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import dlfs_pkg::*;

    localparam int NUM_REGS = REG_FEED_SLOT0 + FEED_SLOTS;
    localparam int ADDR_W   = $clog2(4*NUM_REGS);
    localparam int IDX_W    = ADDR_W - 2;

    // Configuration registers.
    t_minute r_sunrise_minute, r_sunset_minute;
    t_grams  r_feed_amount;
    t_minute r_feed_slot [FEED_SLOTS];
    t_span   r_span_ms;
    t_feed_ms r_feed_ms;

    logic [IDX_W-1:0] reg_idx;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sunrise_minute <= RST_SUNRISE;
            r_sunset_minute  <= RST_SUNSET;
            r_feed_amount    <= RST_FEED_AMT;
        end else if (cfg_write) begin
            if (reg_idx == IDX_W'(REG_SUNRISE)) begin
                r_sunrise_minute <= pwdata[MINUTE_W-1:0];
            end
            if (reg_idx == IDX_W'(REG_SUNSET)) begin
                r_sunset_minute <= pwdata[MINUTE_W-1:0];
            end
            if (reg_idx == IDX_W'(REG_FEED_AMOUNT)) begin
                r_feed_amount <= pwdata[GRAMS_W-1:0];
            end
        end
    end

    for (genvar k = 0; k < FEED_SLOTS; k++) begin : g_slot
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_feed_slot[k] <= RST_FEED_SLOT;
            end else if (cfg_write && reg_idx == IDX_W'(REG_FEED_SLOT0 + k)) begin
                r_feed_slot[k] <= pwdata[MINUTE_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            IDX_W'(REG_SUNRISE):     prdata = 32'(r_sunrise_minute);
            IDX_W'(REG_SUNSET):      prdata = 32'(r_sunset_minute);
            IDX_W'(REG_FEED_AMOUNT): prdata = 32'(r_feed_amount);
            default: begin
                for (int k = 0; k < FEED_SLOTS; k++) begin
                    if (reg_idx == IDX_W'(REG_FEED_SLOT0 + k)) begin
                        prdata = 32'(r_feed_slot[k]);
                    end
                end
            end
        endcase
    end

    // Light span and feed time follow the configuration in the next cycle, which is
    // before any tick taken after a write reaches the logic stage.
    logic [MINUTE_W:0] set_ext, span_min;
    logic              minutes_ok;

    always_comb begin
        minutes_ok = (r_sunrise_minute < DAY_MINUTES) && (r_sunset_minute < DAY_MINUTES);
        set_ext    = {1'b0, r_sunset_minute};
        if (r_sunset_minute < r_sunrise_minute) begin
            set_ext = set_ext + {1'b0, DAY_MINUTES};
        end
        span_min = set_ext - {1'b0, r_sunrise_minute};
        if (span_min >= {1'b0, LIGHT_TRIM_MIN}) begin
            span_min = span_min - {1'b0, LIGHT_TRIM_MIN};
        end
        if (!minutes_ok) begin
            span_min = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_span_ms <= SPAN_W'(span_min) * SPAN_W'(MS_PER_MINUTE);
        r_feed_ms <= FEED_MS_W'(r_feed_amount) * FEED_MS_W'(MS_PER_GRAM);
    end

    // Two-register pipeline: input register, logic, result register.
    logic    r_in_valid, r_out_valid;
    t_tick   r_tick;
    t_result r_result, core_result;
    t_cfg    core_cfg;
    logic    step;

    assign step            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || step;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_result.feeder_on, r_result.light_on,
                              r_result.sunset_pulse, r_result.sunrise_pulse};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_tick.minute_of_day <= i_s_axis_tdata[10:0];
            r_tick.now_ms        <= i_s_axis_tdata[42:11];
            r_tick.feed_now      <= i_s_axis_tdata[43];
        end
        if (step) begin
            r_result <= core_result;
        end
    end

    always_comb begin
        core_cfg.sunrise_minute = r_sunrise_minute;
        core_cfg.sunset_minute  = r_sunset_minute;
        core_cfg.feed_ms        = r_feed_ms;
        core_cfg.span_ms        = r_span_ms;
    end

    dlfs_core #(
        .FEED_SLOTS (FEED_SLOTS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_tick      (r_tick),
        .i_cfg       (core_cfg),
        .i_feed_slot (r_feed_slot),
        .o_result    (core_result)
    );

    // The feeder can only be reported running with a nonzero feed amount.
    `DLFS_ASSERT_NOW(a_feeder_needs_amount, r_out_valid && r_result.feeder_on, r_feed_amount != '0)
    // A sunrise pulse needs a valid sunrise minute.
    `DLFS_ASSERT_NOW(a_rise_minute_valid, r_out_valid && r_result.sunrise_pulse, r_sunrise_minute < DAY_MINUTES)
    // A stalled result must not be overwritten by a tick that moves on.
    `DLFS_ASSERT_NOW(a_no_overrun, r_out_valid && !i_m_axis_tready, !step)

endmodule

`default_nettype wire

>>> test/testbench.sv
// Self-checking testbench of the daily light and feeder scheduler unit.
`default_nettype none

module testbench;
    import dlfs_pkg::*;

    localparam int NUM_SLOTS   = 4;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        tick_valid;
    logic        tick_ready;
    logic [47:0] tick_data;
    logic        relay_valid;
    logic        relay_ready;
    logic [7:0]  relay_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    daily_light_feeder_scheduler_unit #(.FEED_SLOTS(NUM_SLOTS)) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (tick_valid),
        .o_s_axis_tready (tick_ready),
        .i_s_axis_tdata  (tick_data),
        .o_m_axis_tvalid (relay_valid),
        .i_m_axis_tready (relay_ready),
        .o_m_axis_tdata  (relay_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // Shadow copy of the configuration registers.
    t_minute cfg_sunrise;
    t_minute cfg_sunset;
    t_grams  cfg_grams;
    t_minute cfg_slot [NUM_SLOTS];

    // Shadow copy of the scheduler state.
    logic sunrise_busy;
    logic sunset_busy;
    logic light_busy;
    logic feeder_busy;
    t_ms  sunrise_stamp;
    t_ms  sunset_stamp;
    t_ms  light_stamp;
    t_ms  feeder_stamp;
    t_ms  last_feed_stamp;

    t_result predicted_outputs [$];
    t_result head;

    int tx_idle_pct;
    int rx_stall_pct;
    int hold_request;
    int hold_left;
    int quiet_cycles;
    int mismatches;
    int ticks_sent;
    int configs_used;
    int rise_seen;
    int dusk_seen;
    int light_seen;
    int feed_seen;

    int  walk_minute;
    t_ms clock_ms;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic t_ms light_span();
        int unsigned rise;
        int unsigned dusk;
        int unsigned mins;
        rise = cfg_sunrise;
        dusk = cfg_sunset;
        if (rise >= DAY_MINUTES || dusk >= DAY_MINUTES) return '0;
        // A sunset earlier than the sunrise belongs to the next day.
        if (dusk < rise) dusk += DAY_MINUTES;
        mins = dusk - rise;
        if (mins >= LIGHT_TRIM_MIN) mins -= LIGHT_TRIM_MIN;
        return t_ms'(mins * MS_PER_MINUTE);
    endfunction

    function automatic t_result advance_schedule(t_minute minute, t_ms now, logic req);
        t_result r;
        t_ms     feed_ms;
        t_ms     span;
        r = '0;
        feed_ms = t_ms'(cfg_grams) * MS_PER_GRAM;
        span = light_span();

        if (req && !feeder_busy) begin
            feeder_busy = 1'b1;
            feeder_stamp = now;
            last_feed_stamp = now;
        end
        if (cfg_sunrise < DAY_MINUTES && minute == cfg_sunrise && !sunrise_busy) begin
            sunrise_busy = 1'b1;
            sunrise_stamp = now;
            r.sunrise_pulse = 1'b1;
        end
        if (cfg_sunset < DAY_MINUTES && minute == cfg_sunset && !sunset_busy) begin
            sunset_busy = 1'b1;
            sunset_stamp = now;
            r.sunset_pulse = 1'b1;
        end
        // A later slot sees the stamp of an earlier one, so one start per tick at most.
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (cfg_slot[k] < DAY_MINUTES && minute == cfg_slot[k] &&
                    (now - last_feed_stamp) >= FEED_GAP_MS) begin
                feeder_busy = 1'b1;
                feeder_stamp = now;
                last_feed_stamp = now;
            end
        end
        if (sunrise_busy && !light_busy && (now - sunrise_stamp) >= ACTION_MS) begin
            light_busy = 1'b1;
            light_stamp = now;
        end
        if (light_busy && (now - light_stamp) >= span) light_busy = 1'b0;
        if (feeder_busy && (now - feeder_stamp) >= feed_ms) feeder_busy = 1'b0;
        if (sunrise_busy && (now - sunrise_stamp) >= ACTION_MS) sunrise_busy = 1'b0;
        if (sunset_busy && (now - sunset_stamp) >= ACTION_MS) sunset_busy = 1'b0;
        if (feed_ms == '0) feeder_busy = 1'b0;
        if (minute == '0) begin
            sunrise_busy = 1'b0;
            sunset_busy = 1'b0;
        end
        r.light_on = light_busy;
        r.feeder_on = feeder_busy;
        return r;
    endfunction

    task automatic send_tick(t_minute minute, t_ms now, logic req);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            tick_valid <= 1'b0;
            @(negedge i_clk);
        end
        tick_valid <= 1'b1;
        tick_data <= {4'b0, req, now, minute};
        do @(posedge i_clk); while (!tick_ready);
        predicted_outputs.insert(predicted_outputs.size(), advance_schedule(minute, now, req));
        ticks_sent++;
    endtask

    task automatic drain();
        @(negedge i_clk);
        tick_valid <= 1'b0;
        while (predicted_outputs.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(int idx, int unsigned value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(4 * idx);
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SUNRISE:     cfg_sunrise = t_minute'(value);
            REG_SUNSET:      cfg_sunset = t_minute'(value);
            REG_FEED_AMOUNT: cfg_grams = t_grams'(value);
            default:         cfg_slot[idx - REG_FEED_SLOT0] = t_minute'(value);
        endcase
    endtask

    function automatic int unsigned pick_minute();
        case ($urandom_range(9))
            0:       return 0;
            1:       return DAY_MINUTES - 1;
            2:       return $urandom_range(DAY_MINUTES, 2047);
            default: return $urandom_range(0, DAY_MINUTES - 1);
        endcase
    endfunction

    task automatic randomize_schedule();
        int unsigned grams;
        case ($urandom_range(9))
            0:       grams = 0;
            1:       grams = 1000;
            default: grams = $urandom_range(1, 600);
        endcase
        apb_write(REG_SUNRISE, pick_minute());
        apb_write(REG_SUNSET, pick_minute());
        apb_write(REG_FEED_AMOUNT, grams);
        for (int k = 0; k < NUM_SLOTS; k++) apb_write(REG_FEED_SLOT0 + k, pick_minute());
        configs_used++;
    endtask

    // Mostly a clock walking forward through the day, with jumps onto the
    // configured event minutes and some unrelated noise.
    task automatic send_random_tick();
        int   roll;
        int   d;
        int   target;
        logic req;
        roll = $urandom_range(99);
        req = ($urandom_range(99) < 15);
        if (roll < 55) begin
            d = $urandom_range(0, 2);
            walk_minute = (walk_minute + d) % DAY_MINUTES;
            clock_ms += t_ms'(d * MS_PER_MINUTE + $urandom_range(0, 30000));
            send_tick(t_minute'(walk_minute), clock_ms, req);
        end else if (roll < 85) begin
            case ($urandom_range(0, 6))
                0:       target = cfg_sunrise;
                1:       target = cfg_sunset;
                2:       target = cfg_slot[0];
                3:       target = cfg_slot[1];
                4:       target = cfg_slot[2];
                5:       target = cfg_slot[3];
                default: target = 0;
            endcase
            if (target >= DAY_MINUTES) target = $urandom_range(0, DAY_MINUTES - 1);
            walk_minute = target;
            clock_ms += t_ms'($urandom_range(60000, 7200000));
            send_tick(t_minute'(walk_minute), clock_ms, req);
        end else begin
            send_tick(t_minute'($urandom_range(0, 2047)), t_ms'($urandom), req);
        end
    endtask

    task automatic run_random_phase(int count, int tx_pct, int rx_pct);
        drain();
        randomize_schedule();
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        walk_minute = $urandom_range(0, DAY_MINUTES - 1);
        clock_ms = t_ms'($urandom);
        repeat (count) send_random_tick();
    endtask

    task automatic test_reset_defaults();
        configs_used++;
        send_tick(11'd0, 32'd0, 1'b0);
        // Sunrise at the reset minute, with a feed request while the amount is zero.
        send_tick(11'd375, 32'd1000, 1'b1);
        send_tick(11'd376, 32'd61000, 1'b0);
        send_tick(11'd380, 32'd301000, 1'b0);
        send_tick(11'd1210, 32'd50301000, 1'b0);
        send_tick(11'd2047, 32'd50302000, 1'b0);
        send_tick(11'd0, 32'd50400000, 1'b0);
    endtask

    task automatic test_feeder_slots();
        t_ms base;
        base = 32'h8000_0000;
        drain();
        apb_write(REG_SUNRISE, DAY_MINUTES - 1);
        apb_write(REG_SUNSET, 0);
        apb_write(REG_FEED_AMOUNT, 1000);
        apb_write(REG_FEED_SLOT0 + 0, 100);
        apb_write(REG_FEED_SLOT0 + 1, DAY_MINUTES - 1);
        apb_write(REG_FEED_SLOT0 + 2, 0);
        apb_write(REG_FEED_SLOT0 + 3, 2047);
        configs_used++;
        send_tick(11'd100, base, 1'b0);
        // Same slot again inside the 60 s spacing, and a request while running.
        send_tick(11'd100, base + 1000, 1'b1);
        send_tick(11'd100, base + 60000, 1'b0);
        send_tick(11'd101, base + 260000, 1'b0);
        send_tick(11'd500, base + 270000, 1'b1);
        send_tick(11'd1439, base + 400000, 1'b0);
        // Sunset at minute zero is cleared at once by the midnight rule.
        send_tick(11'd0, base + 460000, 1'b0);
    endtask

    task automatic test_light_edges();
        t_ms base;
        base = 32'hFFFF_FF00;
        drain();
        apb_write(REG_SUNRISE, 600);
        apb_write(REG_SUNSET, 600);
        apb_write(REG_FEED_AMOUNT, 1);
        configs_used++;
        send_tick(11'd600, base, 1'b0);
        send_tick(11'd600, base + 100, 1'b1);
        send_tick(11'd601, base + 300, 1'b1);
        // Equal minutes: the light goes on and off within one tick, across the wrap.
        send_tick(11'd605, base + 300000, 1'b0);
        drain();
        apb_write(REG_SUNRISE, 700);
        apb_write(REG_SUNSET, 702);
        configs_used++;
        send_tick(11'd700, 32'd1000000, 1'b0);
        send_tick(11'd705, 32'd1300000, 1'b0);
        send_tick(11'd706, 32'd1420000, 1'b0);
        drain();
        apb_write(REG_SUNRISE, 2047);
        configs_used++;
        send_tick(11'd2047, 32'd1500000, 1'b0);
    endtask

    task automatic test_random_no_idle();
        run_random_phase(100, 0, 0);
    endtask

    task automatic test_random_sender_idle();
        run_random_phase(100, 85, 0);
    endtask

    task automatic test_random_receiver_stall();
        run_random_phase(100, 0, 85);
    endtask

    task automatic test_random_both_idle();
        run_random_phase(100, 12, 12);
    endtask

    // The output side holds off while the input keeps offering requests.
    task automatic test_backpressure();
        drain();
        randomize_schedule();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        walk_minute = $urandom_range(0, DAY_MINUTES - 1);
        clock_ms = t_ms'($urandom);
        hold_request = HOLD_CYCLES;
        repeat (40) send_random_tick();
    endtask

    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            relay_ready <= 1'b0;
        end else begin
            relay_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && relay_valid && relay_ready) begin
            if (predicted_outputs.size() == 0) begin
                report_mismatch($sformatf("result %02h with no pending request", relay_data));
            end else begin
                head = predicted_outputs.pop_front();
                if (relay_data[0] !== head.sunrise_pulse)
                    report_mismatch($sformatf("sunrise_pulse %b, want %b",
                                              relay_data[0], head.sunrise_pulse));
                if (relay_data[1] !== head.sunset_pulse)
                    report_mismatch($sformatf("sunset_pulse %b, want %b",
                                              relay_data[1], head.sunset_pulse));
                if (relay_data[2] !== head.light_on)
                    report_mismatch($sformatf("light_on %b, want %b",
                                              relay_data[2], head.light_on));
                if (relay_data[3] !== head.feeder_on)
                    report_mismatch($sformatf("feeder_on %b, want %b",
                                              relay_data[3], head.feeder_on));
                rise_seen += head.sunrise_pulse;
                dusk_seen += head.sunset_pulse;
                light_seen += head.light_on;
                feed_seen += head.feeder_on;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((tick_valid && tick_ready) || (relay_valid && relay_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        tick_valid = 1'b0;
        tick_data = '0;
        relay_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_sunrise = RST_SUNRISE;
        cfg_sunset = RST_SUNSET;
        cfg_grams = RST_FEED_AMT;
        for (int k = 0; k < NUM_SLOTS; k++) cfg_slot[k] = RST_FEED_SLOT;
        {sunrise_busy, sunset_busy, light_busy, feeder_busy} = '0;
        sunrise_stamp = '0;
        sunset_stamp = '0;
        light_stamp = '0;
        feeder_stamp = '0;
        last_feed_stamp = '0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_request = 0;
        hold_left = 0;
        quiet_cycles = 0;
        mismatches = 0;
        ticks_sent = 0;
        configs_used = 0;
        rise_seen = 0;
        dusk_seen = 0;
        light_seen = 0;
        feed_seen = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_feeder_slots();
        test_light_edges();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_backpressure();
        drain();

        $display("%0d tick requests under %0d register settings, idle and stall phases",
                 ticks_sent, configs_used);
        $display("results held %0d sunrise, %0d sunset, %0d light-on, %0d feeder-on",
                 rise_seen, dusk_seen, light_seen, feed_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+src
src/dlfs_pkg.sv
src/dlfs_core.sv
src/daily_light_feeder_scheduler_unit.sv
test/testbench.sv
